### hw/rtl/otwp_pkg.sv
// Package with shared widths, constants and types for the object-to-window projection block.
package otwp_pkg;
   localparam int COEF_WIDTH = 32;
   localparam int FRAC_BITS = 16;
   localparam int ACC_WIDTH = 2 * COEF_WIDTH + 4;
   localparam int DIV_WIDTH = COEF_WIDTH + 14 + 2 + FRAC_BITS + 2;
   localparam int STORE_DEPTH = 32;
   localparam int STORE_AW = 5;
   localparam int CSR_AW = 4;

   localparam logic [CSR_AW-1:0] ADDR_VIEWPORT_X = 4'h0;
   localparam logic [CSR_AW-1:0] ADDR_VIEWPORT_Y = 4'h4;
   localparam logic [CSR_AW-1:0] ADDR_VIEWPORT_W = 4'h8;
   localparam logic [CSR_AW-1:0] ADDR_VIEWPORT_H = 4'hC;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_PROJECT = 1'b1;

   localparam logic signed [COEF_WIDTH-1:0] CMAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
   localparam logic signed [COEF_WIDTH-1:0] CMIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};
   localparam logic signed [COEF_WIDTH-1:0] ONE_FIXED = COEF_WIDTH'(1) <<< FRAC_BITS;

   typedef logic signed [COEF_WIDTH-1:0] coef_type;

   // Reads a 32-bit two's complement word and saturates it to the coefficient range.
   function automatic coef_type read_in(input logic [31:0] u);
      logic signed [63:0] v;
      v = 64'(signed'(u));
      if (v > 64'(CMAX)) return CMAX;
      if (v < 64'(CMIN)) return CMIN;
      return COEF_WIDTH'(v);
   endfunction
endpackage

### hw/rtl/otwp_ram.sv
// Generic single-port-write RAM with registered read.
module otwp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/object_to_window_projection_top.sv
// Top level of the object-to-window projection block: store, sequencer, MAC and divider.
// A load item is written to the store when it is accepted. A project item runs 32
// multiply-accumulate steps, rounding of each result row, one w check and, when clip w is not zero,
// three divisions on one shared divider before its result is offered.
// The result waits in an output register; the next item is taken once it is accepted,
// so no new item is taken while a project item is in flight or its result waits.
// Synchronous active-high reset sets the viewport to 0, 0, 640 and 480; the store has no reset.
module object_to_window_projection_top
   import otwp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // tdata from bit 0: action[0], coef_index[5:1], coef_value[37:6], obj_x[69:38],
   // obj_y[101:70], obj_z[133:102], zeros[135:134]
   input  logic [135:0]         req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // tdata from bit 0: ok[0], win_x[32:1], win_y[64:33], win_z[96:65], zeros[103:97]
   output logic [103:0]         rsp_tdata,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CSR_AW-1:0]    csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_MUL, ST_ACC, ST_ROUND, ST_WCHECK,
      ST_NUM, ST_DIV, ST_FIX, ST_DONE, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [12:0] vx_ff, vy_ff;
   logic [13:0] vw_ff, vh_ff;

   logic           ram_we;
   logic [STORE_AW-1:0] ram_raddr;
   coef_type       ram_rdata;

   coef_type vec_ff [4], vec_in [4];
   coef_type res_ff [4], res_in [4];
   logic     pass_ff, pass_in;
   logic [1:0] row_ff, row_in, col_ff, col_in;
   logic signed [ACC_WIDTH-1:0] acc_ff, acc_in;
   logic signed [2*COEF_WIDTH-1:0] prod_ff, prod_in;
   logic [1:0] axis_ff, axis_in;
   logic [DIV_WIDTH-1:0] num_ff, num_in, den_ff, den_in, quo_ff, quo_in;
   logic [DIV_WIDTH:0] rem_ff, rem_in;
   logic [$clog2(DIV_WIDTH+1)-1:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in;
   logic [31:0] win_ff [3], win_in [3];
   logic ok_ff, ok_in;

   otwp_ram #(.WIDTH(COEF_WIDTH), .DEPTH(STORE_DEPTH)) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(req_tdata[5:1]),
      .wr_data(read_in(req_tdata[37:6])),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign ram_we = req_tvalid && req_tready && (req_tdata[0] == ACTION_LOAD);
   assign ram_raddr = {pass_ff, col_ff, row_ff};
   assign csr_pready = 1'b1;
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata = {7'd0, win_ff[2], win_ff[1], win_ff[0], ok_ff};

   always_comb begin
      case (csr_paddr)
         ADDR_VIEWPORT_X: csr_prdata = {19'd0, vx_ff};
         ADDR_VIEWPORT_Y: csr_prdata = {19'd0, vy_ff};
         ADDR_VIEWPORT_W: csr_prdata = {18'd0, vw_ff};
         ADDR_VIEWPORT_H: csr_prdata = {18'd0, vh_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   logic signed [ACC_WIDTH-1:0] rnd;
   logic signed [COEF_WIDTH+1:0] cpw;
   logic [14:0] scale;
   logic [12:0] origin;
   logic signed [COEF_WIDTH+16:0] numer;
   logic [DIV_WIDTH:0] rem_sh;
   logic signed [DIV_WIDTH+1:0] qs;
   logic signed [DIV_WIDTH+1:0] wsum;

   always_comb begin
      state_in = state_ff;
      vec_in = vec_ff;
      res_in = res_ff;
      pass_in = pass_ff;
      row_in = row_ff;
      col_in = col_ff;
      acc_in = acc_ff;
      prod_in = prod_ff;
      axis_in = axis_ff;
      num_in = num_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      win_in = win_ff;
      ok_in = ok_ff;
      rnd = (acc_ff + ACC_WIDTH'(1 << (FRAC_BITS-1))) >>> FRAC_BITS;
      case (axis_ff)
         2'd0:    begin scale = {1'b0, vw_ff}; origin = vx_ff; end
         2'd1:    begin scale = {1'b0, vh_ff}; origin = vy_ff; end
         default: begin scale = 15'd1; origin = 13'd0; end
      endcase
      cpw = (COEF_WIDTH+2)'(res_ff[axis_ff]) + (COEF_WIDTH+2)'(res_ff[3]);
      numer = (COEF_WIDTH+17)'(cpw) * signed'({1'b0, scale});
      rem_sh = {rem_ff[DIV_WIDTH-1:0], num_ff[DIV_WIDTH-1]};
      qs = neg_ff ? -(DIV_WIDTH+2)'(quo_ff) : (DIV_WIDTH+2)'(quo_ff);
      wsum = qs + ((DIV_WIDTH+2)'(origin) <<< FRAC_BITS);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tdata[0] == ACTION_PROJECT) begin
               vec_in[0] = read_in(req_tdata[69:38]);
               vec_in[1] = read_in(req_tdata[101:70]);
               vec_in[2] = read_in(req_tdata[133:102]);
               vec_in[3] = ONE_FIXED;
               pass_in = 1'b0;
               row_in = 2'd0;
               col_in = 2'd0;
               acc_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_MUL;
         ST_MUL: begin
            prod_in = ram_rdata * vec_ff[col_ff];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_ff + ACC_WIDTH'(prod_ff);
            col_in = col_ff + 2'd1;
            state_in = (col_ff == 2'd3) ? ST_ROUND : ST_READ;
         end
         ST_ROUND: begin
            if (rnd > ACC_WIDTH'(CMAX)) res_in[row_ff] = CMAX;
            else if (rnd < ACC_WIDTH'(CMIN)) res_in[row_ff] = CMIN;
            else res_in[row_ff] = COEF_WIDTH'(rnd);
            acc_in = '0;
            row_in = row_ff + 2'd1;
            state_in = ST_READ;
            if (row_ff == 2'd3) begin
               if (pass_ff) begin
                  state_in = ST_WCHECK;
               end else begin
                  pass_in = 1'b1;
                  vec_in = res_in;
               end
            end
         end
         ST_WCHECK: begin
            axis_in = 2'd0;
            if (res_ff[3] == '0) begin
               ok_in = 1'b0;
               win_in[0] = '0;
               win_in[1] = '0;
               win_in[2] = '0;
               state_in = ST_OUT;
            end else begin
               ok_in = 1'b1;
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            // Quotient of (2*|n|*2^F + 2|w|) / (4|w|) rounds to nearest, ties away from zero.
            neg_in = numer[COEF_WIDTH+16] ^ res_ff[3][COEF_WIDTH-1];
            num_in = (DIV_WIDTH'(numer[COEF_WIDTH+16] ? -numer : numer) << (FRAC_BITS+1))
                     + (DIV_WIDTH'(res_ff[3][COEF_WIDTH-1] ? -res_ff[3] : res_ff[3]) << 1);
            den_in = DIV_WIDTH'(res_ff[3][COEF_WIDTH-1] ? -res_ff[3] : res_ff[3]) << 2;
            rem_in = '0;
            quo_in = '0;
            cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            num_in = num_ff << 1;
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rem_sh - {1'b0, den_ff};
               quo_in = {quo_ff[DIV_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[DIV_WIDTH-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ($bits(cnt_ff))'(DIV_WIDTH-1)) state_in = ST_FIX;
         end
         ST_FIX: begin
            if (wsum > (DIV_WIDTH+2)'(signed'(32'h7FFFFFFF))) win_in[axis_ff] = 32'h7FFFFFFF;
            else if (wsum < -(DIV_WIDTH+2)'(signed'(64'h80000000)))
               win_in[axis_ff] = 32'h80000000;
            else win_in[axis_ff] = wsum[31:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            axis_in = axis_ff + 2'd1;
            state_in = (axis_ff == 2'd2) ? ST_OUT : ST_NUM;
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vx_ff <= 13'd0;
         vy_ff <= 13'd0;
         vw_ff <= 14'd640;
         vh_ff <= 14'd480;
      end else begin
         state_ff <= state_in;
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_paddr)
               ADDR_VIEWPORT_X: vx_ff <= csr_pwdata[12:0];
               ADDR_VIEWPORT_Y: vy_ff <= csr_pwdata[12:0];
               ADDR_VIEWPORT_W: vw_ff <= csr_pwdata[13:0];
               ADDR_VIEWPORT_H: vh_ff <= csr_pwdata[13:0];
               default: ;
            endcase
         end
      end
      vec_ff <= vec_in;
      res_ff <= res_in;
      pass_ff <= pass_in;
      row_ff <= row_in;
      col_ff <= col_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      axis_ff <= axis_in;
      num_ff <= num_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      win_ff <= win_in;
      ok_ff <= ok_in;
   end
endmodule

### dv/object_to_window_projection_checker.sv
// Checker that predicts window coordinates from accepted items and compares each result.
module object_to_window_projection_checker
   import otwp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  logic           req_tready,
   input  logic [135:0]   req_tdata,
   input  logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  logic [103:0]   rsp_tdata,
   input  logic           csr_psel,
   input  logic           csr_penable,
   input  logic           csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]    csr_pwdata,
   input  logic           csr_pready,
   output int             fail_count,
   output int             pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                   ok;
      logic signed [31:0]     win_x;
      logic signed [31:0]     win_y;
      logic signed [31:0]     win_z;
   } window_point_type;

   coef_type       matrix_store [STORE_DEPTH];
   logic [12:0]    origin_x, origin_y;
   logic [13:0]    extent_w, extent_h;
   window_point_type expected_points[$];

   function automatic coef_type round_row(logic signed [127:0] acc);
      logic signed [127:0] r;
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      hi_lim = CMAX;
      lo_lim = CMIN;
      r = (acc + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (r > hi_lim) return CMAX;
      if (r < lo_lim) return CMIN;
      return coef_type'(r);
   endfunction

   function automatic coef_type matrix_row(int base, int row, coef_type v0, coef_type v1,
                                           coef_type v2, coef_type v3);
      logic signed [127:0] acc;
      logic signed [127:0] a, b;
      coef_type vec [4];
      vec[0] = v0;
      vec[1] = v1;
      vec[2] = v2;
      vec[3] = v3;
      acc = 0;
      for (int col = 0; col < 4; col++) begin
         a = matrix_store[base + col * 4 + row];
         b = vec[col];
         acc = acc + a * b;
      end
      return round_row(acc);
   endfunction

   function automatic logic signed [31:0] map_to_window(coef_type c, coef_type w,
                                                       logic [13:0] scale, logic [12:0] origin);
      logic signed [127:0] ce, we, num, den, q, hi_lim, lo_lim;
      logic neg;
      ce = c;
      we = w;
      num = $signed({114'd0, scale}) * (ce + we);
      den = we <<< 1;
      neg = num[127] != den[127];
      num = num <<< FRAC_BITS;
      if (num < 0) num = -num;
      if (den < 0) den = -den;
      q = ((num <<< 1) + den) / (den <<< 1);
      if (neg) q = -q;
      q = q + ($signed({115'd0, origin}) <<< FRAC_BITS);
      hi_lim = 128'sh7FFF_FFFF;
      lo_lim = -128'sh8000_0000;
      if (q > hi_lim) return 32'sh7FFF_FFFF;
      if (q < lo_lim) return 32'sh8000_0000;
      return q[31:0];
   endfunction

   function automatic window_point_type project_point(coef_type px, coef_type py, coef_type pz);
      coef_type eye [4];
      coef_type clip [4];
      window_point_type res;
      coef_type one;
      one = ONE_FIXED;
      for (int r = 0; r < 4; r++) eye[r] = matrix_row(0, r, px, py, pz, one);
      for (int r = 0; r < 4; r++) clip[r] = matrix_row(16, r, eye[0], eye[1], eye[2], eye[3]);
      res = '0;
      if (clip[3] == 0) return res;
      res.ok = 1'b1;
      res.win_x = map_to_window(clip[0], clip[3], extent_w, origin_x);
      res.win_y = map_to_window(clip[1], clip[3], extent_h, origin_y);
      res.win_z = map_to_window(clip[2], clip[3], 14'd1, 13'd0);
      return res;
   endfunction

   always @(posedge clock) begin
      window_point_type got, want;
      if (reset) begin
         origin_x = 0;
         origin_y = 0;
         extent_w = 640;
         extent_h = 480;
         expected_points.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               ADDR_VIEWPORT_X: origin_x = csr_pwdata[12:0];
               ADDR_VIEWPORT_Y: origin_y = csr_pwdata[12:0];
               ADDR_VIEWPORT_W: extent_w = csr_pwdata[13:0];
               ADDR_VIEWPORT_H: extent_h = csr_pwdata[13:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tdata[0] == ACTION_LOAD)
               matrix_store[req_tdata[5:1]] = read_in(req_tdata[37:6]);
            else
               expected_points.push_back(project_point(read_in(req_tdata[69:38]),
                  read_in(req_tdata[101:70]), read_in(req_tdata[133:102])));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.ok = rsp_tdata[0];
            got.win_x = rsp_tdata[32:1];
            got.win_y = rsp_tdata[64:33];
            got.win_z = rsp_tdata[96:65];
            if (expected_points.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("Unexpected item: ok=%0d x=%h y=%h z=%h",
                           got.ok, got.win_x, got.win_y, got.win_z);
            end else begin
               want = expected_points.pop_front();
               if (got != want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("Mismatch: expected ok=%0d x=%h y=%h z=%h, got ok=%0d x=%h y=%h z=%h",
                              want.ok, want.win_x, want.win_y, want.win_z,
                              got.ok, got.win_x, got.win_y, got.win_z);
               end
            end
         end
      end
      pending_count = expected_points.size();
   end
endmodule

### dv/tb_top.sv
// Testbench top that drives matrix loads, projections and viewport settings and gives the verdict.
module tb_top;
   import otwp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 400;
   localparam int STALL_LIMIT = 5000;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_tvalid = 1'b0;
   logic           req_tready;
   logic [135:0]   req_tdata = '0;
   logic           rsp_tvalid;
   logic           rsp_tready = 1'b0;
   logic [103:0]   rsp_tdata;
   logic           csr_psel = 1'b0;
   logic           csr_penable = 1'b0;
   logic           csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]    csr_pwdata = '0;
   logic [31:0]    csr_prdata;
   logic           csr_pready;
   int             fail_count;
   int             pending_count;
   int             quiet_cycles = 0;
   bit             no_idle = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   object_to_window_projection_top dut (.*);

   object_to_window_projection_checker checker_i (.*);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int stall;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_item(logic action, logic [4:0] idx, logic [31:0] val,
                            logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, pz, py, px, val, idx, action};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic load_coef(int idx, logic [31:0] val);
      send_item(ACTION_LOAD, idx[4:0], val, $urandom, $urandom, $urandom);
   endtask

   task automatic project(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      send_item(ACTION_PROJECT, 5'($urandom), $urandom, px, py, pz);
   endtask

   task automatic csr_write(logic [CSR_AW-1:0] addr, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_viewport(logic [31:0] vx, logic [31:0] vy, logic [31:0] vw,
                               logic [31:0] vh);
      csr_write(ADDR_VIEWPORT_X, vx);
      csr_write(ADDR_VIEWPORT_Y, vy);
      csr_write(ADDR_VIEWPORT_W, vw);
      csr_write(ADDR_VIEWPORT_H, vh);
   endtask

   function automatic logic [31:0] random_coef();
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return $urandom;
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      endcase
   endfunction

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 19))
         0, 1: return $urandom;
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
      endcase
   endfunction

   initial begin
      logic [31:0] one;
      one = 32'h0001_0000;
      @(negedge reset);
      @(posedge clock);
      set_viewport(10, 20, 640, 480);

      // Modelview with a unit diagonal, an x translation and a zero w row, and a simple perspective projection.
      for (int i = 0; i < 32; i++) load_coef(i, 32'h0);
      load_coef(0, one);
      load_coef(5, one);
      load_coef(10, one);
      load_coef(12, 32'h0000_8000);
      load_coef(16, one);
      load_coef(21, one);
      load_coef(26, -one);
      load_coef(27, -one);
      load_coef(30, -32'h0000_3333);
      project(32'h0000_4000, -32'h0000_4000, -32'h0002_0000);
      project(32'h0, 32'h0, 32'h0);
      project(32'h7FFF_FFFF, 32'h8000_0000, -32'h0000_0001);
      project(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      project(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
      load_coef(0, 32'h7FFF_FFFF);
      project(one, one, -one);
      load_coef(0, 32'h8000_0000);
      project(one, -one, -one);
      load_coef(0, one);

      for (int phase = 0; phase < 8; phase++) begin
         drain();
         case (phase)
            0: set_viewport(0, 0, 0, 0);
            1: set_viewport(8191, 8191, 8192, 8192);
            2: set_viewport(8191, 0, 16383, 16383);
            default: set_viewport($urandom, $urandom, $urandom, $urandom);
         endcase
         for (int n = 0; n < 100; n++) begin
            no_idle = (n % 40) < 8;
            if ($urandom_range(0, 99) < 3) begin
               for (int c = 0; c < 4; c++) load_coef(16 + c * 4 + 3, 32'h0);
            end else if ($urandom_range(0, 99) < 15) begin
               load_coef($urandom_range(0, 31), random_coef());
            end else begin
               project(random_coord(), random_coord(), random_coord());
            end
         end
      end
      no_idle = 1'b0;
      drain();
      if (fail_count == 0 && pending_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

### sim.f
hw/rtl/otwp_pkg.sv
hw/rtl/otwp_ram.sv
hw/rtl/object_to_window_projection_top.sv
dv/object_to_window_projection_checker.sv
dv/tb_top.sv
